// File: hdl/wpts_pkg.sv
// shared types and constants for the world point to screen projection core
// no dependencies
package wpts_pkg;

  localparam int FracBitsDefault = 16;
  localparam int WinWidth        = 14;
  localparam int DataWidth       = 32;
  localparam int CfgIndexWidth   = 1;

  localparam logic [WinWidth-1:0] WidthReset  = 14'd1920;
  localparam logic [WinWidth-1:0] HeightReset = 14'd1080;

  localparam logic [CfgIndexWidth-1:0] RegWindowWidth  = 1'b0;
  localparam logic [CfgIndexWidth-1:0] RegWindowHeight = 1'b1;

  localparam logic FuncWriteCoef = 1'b0;
  localparam logic FuncProject   = 1'b1;

  typedef struct packed {
    logic               func;
    logic [3:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic               visible;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic       load_point;  // capture point
    logic       coef_write;  // store coefficient from input
    logic       acc_clear;   // clear accumulator, preload translation
    logic       mac_mul;     // register product of selected terms
    logic       mac_add;     // add registered product into accumulator
    logic [1:0] term;        // 0..2 = x,y,z
    logic [1:0] row;         // 0 = x, 1 = y, 2 = w
    logic       clip_store;  // saturate accumulator into clip row
    logic       div_start;   // start division of clip row by w
    logic       div_sel;     // 0 = x, 1 = y
    logic       map_mul;     // register screen products
    logic       map_fin;     // form screen value
    logic       out_load;    // load output register
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic w_ok;
    logic div_busy;
  } ctrl_sts_t;

endpackage

// File: hdl/wpts_divider.sv
// restoring radix-2 signed divider, one quotient bit per cycle
// no dependencies; the widths are handed down as parameters
module wpts_divider #(
  parameter int NumWidth = 48,
  parameter int DenWidth = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [NumWidth-1:0] num,
  input  logic signed [DenWidth-1:0] den,
  output logic                       busy,
  output logic signed [NumWidth-1:0] quot
);

  localparam int CntWidth = $clog2(NumWidth + 1);

  logic [NumWidth-1:0] q;
  logic [DenWidth:0]   rem;
  logic [DenWidth-1:0] dmag;
  logic                neg;
  logic [CntWidth-1:0] cnt;
  logic [DenWidth+1:0] trial;
  logic [DenWidth+1:0] shifted;

  assign shifted = {rem, q[NumWidth-1]};
  assign trial   = shifted - {2'b00, dmag};

  // magnitude division, sign fixed at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CntWidth'(NumWidth);
      q    <= num[NumWidth-1] ? NumWidth'(-num) : num;
      dmag <= den[DenWidth-1] ? DenWidth'(-den) : den;
      neg  <= num[NumWidth-1] ^ den[DenWidth-1];
      rem  <= '0;
    end else if (busy) begin
      if (!trial[DenWidth+1]) begin
        rem <= trial[DenWidth:0];
        q   <= {q[NumWidth-2:0], 1'b1};
      end else begin
        rem <= shifted[DenWidth:0];
        q   <= {q[NumWidth-2:0], 1'b0};
      end
      cnt <= cnt - CntWidth'(1);
      if (cnt == CntWidth'(1)) busy <= 1'b0;
    end
  end

  assign quot = neg ? NumWidth'(-q) : q;

endmodule

// File: hdl/wpts_datapath.sv
// datapath: coefficient store, shared multiply-accumulate, divider and mapping
// depends on wpts_pkg and wpts_divider
module wpts_datapath #(
  parameter int FracBits = wpts_pkg::FracBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  wpts_pkg::in_item_t   item,
  input  logic                 cfg_we,
  input  logic [wpts_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [wpts_pkg::WinWidth-1:0]      cfg_data,
  input  wpts_pkg::ctrl_cmd_t  cmd,
  output wpts_pkg::ctrl_sts_t  sts,
  output wpts_pkg::out_item_t  result
);

  localparam int DW      = wpts_pkg::DataWidth;
  // three shifted products plus the translation term, with headroom
  localparam int AccW    = 2 * DW - FracBits + 3;
  localparam int NumW    = DW + FracBits + 1;
  localparam int WMin    = ((1 << FracBits) + 5) / 10;
  localparam int MapW    = NumW + wpts_pkg::WinWidth + 2;

  logic signed [DW-1:0] coef [16];
  logic [15:0]          coef_valid;
  logic [wpts_pkg::WinWidth-1:0] win_w, win_h;
  logic signed [DW-1:0] px, py, pz;
  logic signed [2*DW-1:0] prod;
  logic signed [AccW-1:0] acc;
  logic signed [DW-1:0] clip_x, clip_y, clip_w;
  logic signed [NumW-1:0] ndc;
  logic signed [MapW-1:0] map_p;
  logic signed [MapW-1:0] map_s;
  logic div_busy;

  logic signed [DW-1:0] pt_sel, cf_sel, tr_sel;
  logic signed [AccW-1:0] acc_sat_src;
  logic signed [DW-1:0] acc_sat;
  logic signed [NumW-1:0] div_num;
  logic signed [DW-1:0] div_src;
  logic [wpts_pkg::WinWidth-2:0] half;
  logic signed [wpts_pkg::WinWidth+1:0] factor;
  logic signed [DW-1:0] screen_sat;

  function automatic logic signed [DW-1:0] coef_rd(input logic [3:0] idx,
      input logic signed [DW-1:0] c [16], input logic [15:0] v);
    coef_rd = v[idx] ? c[idx] : '0;
  endfunction

  // configuration and coefficient storage
  always_ff @(posedge clk) begin
    if (rst) begin
      win_w      <= wpts_pkg::WidthReset;
      win_h      <= wpts_pkg::HeightReset;
      coef_valid <= '0;
    end else begin
      if (cfg_we && cfg_index == wpts_pkg::RegWindowWidth)  win_w <= cfg_data;
      if (cfg_we && cfg_index == wpts_pkg::RegWindowHeight) win_h <= cfg_data;
      if (cmd.coef_write) coef_valid[item.coef_index] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.coef_write) coef[item.coef_index] <= item.coef_value;
    if (cmd.load_point) begin
      px <= item.point_x;
      py <= item.point_y;
      pz <= item.point_z;
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    logic [1:0] r;
    r = (cmd.row == 2'd2) ? 2'd3 : cmd.row;
    case (cmd.term)
      2'd0:    pt_sel = px;
      2'd1:    pt_sel = py;
      default: pt_sel = pz;
    endcase
    cf_sel = coef_rd({cmd.term, r}, coef, coef_valid);
    tr_sel = coef_rd({2'd3, r}, coef, coef_valid);
  end

  assign acc_sat_src = acc;
  always_comb begin
    if (acc_sat_src > AccW'(signed'({1'b0, {(DW-1){1'b1}}})))
      acc_sat = {1'b0, {(DW-1){1'b1}}};
    else if (acc_sat_src < -(AccW'(signed'({1'b0, {(DW-1){1'b1}}}))) - 1)
      acc_sat = {1'b1, {(DW-1){1'b0}}};
    else
      acc_sat = acc_sat_src[DW-1:0];
  end

  // multiply-accumulate, floor shift via arithmetic shift
  always_ff @(posedge clk) begin
    if (cmd.mac_mul) prod <= pt_sel * cf_sel;
    if (cmd.acc_clear) acc <= AccW'(tr_sel);
    else if (cmd.mac_add) acc <= acc + AccW'(prod >>> FracBits);
    if (cmd.clip_store) begin
      case (cmd.row)
        2'd0:    clip_x <= acc_sat;
        2'd1:    clip_y <= acc_sat;
        default: clip_w <= acc_sat;
      endcase
    end
  end

  assign sts.w_ok     = clip_w >= DW'(WMin);
  assign sts.div_busy = div_busy;

  assign div_src = cmd.div_sel ? clip_y : clip_x;
  assign div_num = NumW'(div_src) <<< FracBits;

  wpts_divider #(.NumWidth(NumW), .DenWidth(DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (clip_w),
    .busy  (div_busy),
    .quot  (ndc)
  );

  // mapping: x = (hw+1)*ndc + hw*one, y = (1-hh)*ndc + hh*one
  assign half   = cmd.div_sel ? win_h[wpts_pkg::WinWidth-1:1] : win_w[wpts_pkg::WinWidth-1:1];
  assign factor = cmd.div_sel ? (16'sd1 - $signed({3'b0, half}))
                              : ($signed({3'b0, half}) + 16'sd1);

  always_comb begin
    if (map_s > MapW'(signed'({1'b0, {(DW-1){1'b1}}})))
      screen_sat = {1'b0, {(DW-1){1'b1}}};
    else if (map_s < -(MapW'(signed'({1'b0, {(DW-1){1'b1}}}))) - 1)
      screen_sat = {1'b1, {(DW-1){1'b0}}};
    else
      screen_sat = map_s[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.map_mul) map_p <= MapW'(ndc) * MapW'(factor);
    if (cmd.map_fin)
      map_s <= map_p + (MapW'($signed({1'b0, half})) <<< FracBits);
    if (cmd.out_load) begin
      result.visible <= sts.w_ok;
      if (!sts.w_ok) begin
        result.screen_x <= '0;
        result.screen_y <= '0;
      end else if (cmd.div_sel) begin
        result.screen_y <= screen_sat;
      end else begin
        result.screen_x <= screen_sat;
      end
    end
  end

endmodule

// File: hdl/wpts_ctrl.sv
// controller: sequences coefficient writes and projections, runs the handshake
// depends on wpts_pkg
module wpts_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_func,
  output logic                out_valid,
  input  logic                out_stall,
  output wpts_pkg::ctrl_cmd_t cmd,
  input  wpts_pkg::ctrl_sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_MUL, S_ADD, S_STORE, S_CHECK, S_DIV, S_WAIT,
    S_MAP, S_FIN, S_OUT, S_HOLD
  } state_t;

  state_t     state;
  logic [1:0] row, term;
  logic       dsel;
  logic       accept;

  // take an item when idle and no result is held under a stall
  assign in_stall = !(state == S_IDLE && !(out_valid && out_stall));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd = '0;
    cmd.row     = row;
    cmd.term    = term;
    cmd.div_sel = dsel;
    case (state)
      S_IDLE: begin
        cmd.load_point = accept && in_func == wpts_pkg::FuncProject;
        cmd.coef_write = accept && in_func == wpts_pkg::FuncWriteCoef;
      end
      S_CLR:   cmd.acc_clear = 1'b1;
      S_MUL:   cmd.mac_mul = 1'b1;
      S_ADD:   cmd.mac_add = 1'b1;
      S_STORE: cmd.clip_store = 1'b1;
      S_DIV:   cmd.div_start = 1'b1;
      S_MAP:   cmd.map_mul = 1'b1;
      S_FIN:   cmd.map_fin = 1'b1;
      S_OUT:   cmd.out_load = 1'b1;
      S_CHECK: cmd.out_load = !sts.w_ok;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      row       <= '0;
      term      <= '0;
      dsel      <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && in_func == wpts_pkg::FuncProject) begin
            state <= S_CLR;
            row   <= 2'd0;
            term  <= 2'd0;
          end
        end
        S_CLR: state <= S_MUL;
        S_MUL: state <= S_ADD;
        S_ADD: begin
          if (term == 2'd2) begin
            state <= S_STORE;
          end else begin
            term  <= term + 2'd1;
            state <= S_MUL;
          end
        end
        S_STORE: begin
          term <= 2'd0;
          if (row == 2'd2) begin
            state <= S_CHECK;
          end else begin
            row   <= row + 2'd1;
            state <= S_CLR;
          end
        end
        S_CHECK: begin
          dsel <= 1'b0;
          if (sts.w_ok) state <= S_DIV;
          else state <= S_HOLD;
        end
        S_DIV:  state <= S_WAIT;
        S_WAIT: if (!sts.div_busy) state <= S_MAP;
        S_MAP:  state <= S_FIN;
        S_FIN:  state <= S_OUT;
        S_OUT: begin
          if (dsel) begin
            state <= S_HOLD;
          end else begin
            dsel  <= 1'b1;
            state <= S_DIV;
          end
        end
        S_HOLD: begin
          if (!(out_valid && out_stall)) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/world_point_to_screen_core.sv
// World point to screen projection core.
// One input channel (in_valid/in_stall/in_item) and one output channel
// (out_valid/out_stall/out_item). func=0 transactions write one view matrix
// coefficient and give no result; one is taken per cycle while not stalled.
// func=1 transactions project a Q16.16 point and give one result transaction.
// A projection runs nine multiply-accumulate steps on one shared 32x32
// multiplier, with accumulator clears and clip stores between rows, a w check,
// then two 49-step radix-2 divisions by clip w, each followed by mapping; the
// result is valid when the second mapping is done, and the next item can be
// taken once the result is in the output register. A point behind the viewer
// (w below 0.1) skips the divisions and gives its result after the w check.
// One item is in work at a time. A finished result sits in the output
// register; while the receiver stalls it, the input is stalled too.
// User writes window size on cfg port only while core is idle; not enforced.
// Reset (rst, synchronous) clears the matrix to zero and sets the window
// to 1920 by 1080; no clearing pass is needed.
module world_point_to_screen_core #(
  parameter int FracBits = wpts_pkg::FracBitsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  wpts_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output wpts_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [wpts_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [wpts_pkg::WinWidth-1:0]      cfg_data
);

  wpts_pkg::ctrl_cmd_t cmd;
  wpts_pkg::ctrl_sts_t sts;

  // sequencer
  wpts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_func   (in_item.func),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // arithmetic
  wpts_datapath #(.FracBits(FracBits)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .result    (out_item)
  );

endmodule

// File: hdl/wpts_checker.sv
// port-level checker for the projection core, bound to the top level
// depends on wpts_pkg
module wpts_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input wpts_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_stall,
  input wpts_pkg::out_item_t out_item
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed under stall");

  // hidden points report zero coordinates
  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.visible |-> out_item.screen_x == 0 && out_item.screen_y == 0)
    else $error("hidden point with nonzero position");

  // a projection accepted keeps the core busy next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_item.func == wpts_pkg::FuncProject |=> in_stall)
    else $error("accepted during projection");

  // no result right after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

endmodule

bind world_point_to_screen_core wpts_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
